// ----- src/hvcc_parameter_set_parser_defines.svh -----
// Assertion macros for the verification file of the parameter set parser.
`ifndef HVCC_PARAMETER_SET_PARSER_DEFINES_SVH
`define HVCC_PARAMETER_SET_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HVCC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hvcc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HVCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hvcc assertion failed");

`endif

// ----- src/hvcc_pkg.sv -----
package hvcc_pkg;

    // Header length of the configuration record and the index of its last byte.
    localparam int HDR_LEN = 23;
    localparam logic [4:0] HDR_LAST = 5'(HDR_LEN - 1);

    // Parser phases.
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_ATYPE   = 3'd1;
    localparam logic [2:0] PH_CNT_HI  = 3'd2;
    localparam logic [2:0] PH_CNT_LO  = 3'd3;
    localparam logic [2:0] PH_SIZE_HI = 3'd4;
    localparam logic [2:0] PH_SIZE_LO = 3'd5;
    localparam logic [2:0] PH_BODY    = 3'd6;
    localparam logic [2:0] PH_END     = 3'd7;

    // Status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER = 3'd1;
    localparam logic [2:0] ST_TRUNC_ARR  = 3'd2;
    localparam logic [2:0] ST_TRUNC_CNT  = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd4;
    localparam logic [2:0] ST_TYPE_MISM  = 3'd5;
    localparam logic [2:0] ST_TRAILING   = 3'd6;

    // Position of a byte inside a NAL body.
    localparam logic [1:0] IDX_FIRST  = 2'd0;
    localparam logic [1:0] IDX_SECOND = 2'd1;
    localparam logic [1:0] IDX_GOOD   = 2'd2;
    localparam logic [1:0] IDX_BAD    = 2'd3;

    // NAL types of the parameter sets that are passed on as payload.
    localparam logic [5:0] NAL_VPS = 6'd32;
    localparam logic [5:0] NAL_PPS = 6'd34;

    // Depth of the queue between the front and the back end.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // One received byte with its precomputed classification.
    typedef struct packed {
        logic [7:0] data;
        logic       is_end;
        logic       is_one;
        logic [5:0] low_type;
        logic       tid_nz;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       payload_valid;
        logic [1:0] set_kind;
        logic       nal_first;
        logic       nal_last;
        logic       record_done;
        logic [2:0] status;
    } res_t;

endpackage

// ----- src/hvcc_front.sv -----
module hvcc_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_record_byte,
    input  logic          s_record_end,
    output logic          q_push,
    output hvcc_pkg::item_t q_item,
    input  logic          q_ready
);
    import hvcc_pkg::*;

    logic  front_valid_reg, front_valid_next;
    item_t front_item_reg, front_item_next;

    assign s_ready = !front_valid_reg || q_ready;
    assign q_push  = front_valid_reg && q_ready;
    assign q_item  = front_item_reg;

    always_comb begin
        front_item_next  = front_item_reg;
        front_valid_next = front_valid_reg;
        if (q_push) begin
            front_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            front_valid_next        = 1'b1;
            front_item_next.data    = s_record_byte;
            front_item_next.is_end  = s_record_end;
            front_item_next.is_one  = (s_record_byte == 8'd1);
            front_item_next.low_type = s_record_byte[5:0];
            front_item_next.tid_nz  = |s_record_byte[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
        front_item_reg <= front_item_next;
    end

endmodule

// ----- src/hvcc_queue.sv -----
module hvcc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  hvcc_pkg::item_t push_item,
    output logic            push_ready,
    input  logic            pop,
    output logic            pop_valid,
    output hvcc_pkg::item_t pop_item
);
    import hvcc_pkg::*;

    item_t          entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;

    assign push_ready = (count_reg != (QAW+1)'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- src/hvcc_back.sv -----
module hvcc_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  hvcc_pkg::item_t q_item,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output hvcc_pkg::res_t  m_res
);
    import hvcc_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [4:0]  hdr_pos_reg, hdr_pos_next;
    logic [7:0]  arrays_reg, arrays_next;
    logic [5:0]  atype_reg, atype_next;
    logic [15:0] nals_reg, nals_next;
    logic [15:0] nal_rem_reg, nal_rem_next;
    logic [7:0]  pend_reg, pend_next;
    logic [1:0]  idx_reg, idx_next;
    logic [2:0]  err_reg, err_next;
    logic        out_valid_reg, out_valid_next;
    res_t        res_reg, res_next;

    // The output register takes a new byte whenever it is empty or being drained.
    assign q_pop   = q_valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_res   = res_reg;

    always_comb begin
        logic        pv;
        logic        first;
        logic        last;
        logic        is_last;
        logic        ok;
        logic [7:0]  arr_dec;
        logic [15:0] nals_dec;
        logic [15:0] word;
        phase_next     = phase_reg;
        hdr_pos_next   = hdr_pos_reg;
        arrays_next    = arrays_reg;
        atype_next     = atype_reg;
        nals_next      = nals_reg;
        nal_rem_next   = nal_rem_reg;
        pend_next      = pend_reg;
        idx_next       = idx_reg;
        err_next       = err_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        pv       = 1'b0;
        first    = 1'b0;
        last     = 1'b0;
        is_last  = (nal_rem_reg == 16'd1);
        ok       = !pend_reg[7] && (pend_reg[6:1] == atype_reg) && q_item.tid_nz;
        arr_dec  = arrays_reg - 8'd1;
        nals_dec = nals_reg - 16'd1;
        word     = {pend_reg, q_item.data};

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (q_pop) begin
            out_valid_next = 1'b1;
            if (err_reg == ST_OK) begin
                case (phase_reg)
                    PH_HEADER: begin
                        if (hdr_pos_reg == 5'd0 && !q_item.is_one) begin
                            err_next = ST_BAD_HEADER;
                        end else if (hdr_pos_reg >= HDR_LAST) begin
                            arrays_next = q_item.data;
                            phase_next  = (q_item.data != 8'd0) ? PH_ATYPE : PH_END;
                        end else begin
                            hdr_pos_next = hdr_pos_reg + 5'd1;
                        end
                    end
                    PH_ATYPE: begin
                        atype_next = q_item.low_type;
                        phase_next = PH_CNT_HI;
                    end
                    PH_CNT_HI: begin
                        pend_next  = q_item.data;
                        phase_next = PH_CNT_LO;
                    end
                    PH_CNT_LO: begin
                        nals_next = word;
                        if (word == 16'd0) begin
                            arrays_next = arr_dec;
                            phase_next  = (arr_dec != 8'd0) ? PH_ATYPE : PH_END;
                        end else begin
                            phase_next = PH_SIZE_HI;
                        end
                    end
                    PH_SIZE_HI: begin
                        pend_next  = q_item.data;
                        phase_next = PH_SIZE_LO;
                    end
                    PH_SIZE_LO: begin
                        nal_rem_next = word;
                        if (word == 16'd0) begin
                            err_next = ST_BAD_SIZE;
                        end else begin
                            idx_next   = IDX_FIRST;
                            phase_next = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        first = (idx_reg == IDX_FIRST);
                        last  = is_last;
                        pv    = (atype_reg >= NAL_VPS) && (atype_reg <= NAL_PPS);
                        if (idx_reg == IDX_FIRST) begin
                            pend_next = q_item.data;
                            if (is_last) begin
                                err_next = ST_TYPE_MISM;
                            end else begin
                                idx_next = IDX_SECOND;
                            end
                        end else if (idx_reg == IDX_SECOND) begin
                            idx_next = ok ? IDX_GOOD : IDX_BAD;
                            if (is_last && !ok) begin
                                err_next = ST_TYPE_MISM;
                            end
                        end else if (is_last && idx_reg == IDX_BAD) begin
                            err_next = ST_TYPE_MISM;
                        end
                        nal_rem_next = nal_rem_reg - 16'd1;
                        if (is_last && err_next == ST_OK) begin
                            nals_next = nals_dec;
                            if (nals_dec == 16'd0) begin
                                arrays_next = arr_dec;
                                phase_next  = (arr_dec != 8'd0) ? PH_ATYPE : PH_END;
                            end else begin
                                phase_next = PH_SIZE_HI;
                            end
                        end
                    end
                    PH_END: begin
                        err_next = ST_TRAILING;
                    end
                    default: begin
                        err_next = ST_TRAILING;
                    end
                endcase
            end

            // A record that stops early gets a verdict from where it stopped.
            if (q_item.is_end && err_next == ST_OK) begin
                case (phase_next)
                    PH_HEADER: err_next = ST_BAD_HEADER;
                    PH_ATYPE:  err_next = ST_TRUNC_ARR;
                    PH_CNT_HI: err_next = ST_TRUNC_CNT;
                    PH_CNT_LO: err_next = ST_TRUNC_CNT;
                    PH_END:    err_next = ST_OK;
                    default:   err_next = ST_BAD_SIZE;
                endcase
            end

            res_next.out_byte      = q_item.data;
            res_next.payload_valid = pv;
            res_next.set_kind      = pv ? atype_reg[1:0] : 2'd0;
            res_next.nal_first     = first;
            res_next.nal_last      = last;
            res_next.record_done   = q_item.is_end;
            res_next.status        = err_next;

            if (q_item.is_end) begin
                phase_next   = PH_HEADER;
                hdr_pos_next = 5'd0;
                arrays_next  = 8'd0;
                atype_next   = 6'd0;
                nals_next    = 16'd0;
                nal_rem_next = 16'd0;
                pend_next    = 8'd0;
                idx_next     = IDX_FIRST;
                err_next     = ST_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            hdr_pos_reg   <= 5'd0;
            arrays_reg    <= 8'd0;
            atype_reg     <= 6'd0;
            nals_reg      <= 16'd0;
            nal_rem_reg   <= 16'd0;
            pend_reg      <= 8'd0;
            idx_reg       <= IDX_FIRST;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            hdr_pos_reg   <= hdr_pos_next;
            arrays_reg    <= arrays_next;
            atype_reg     <= atype_next;
            nals_reg      <= nals_next;
            nal_rem_reg   <= nal_rem_next;
            pend_reg      <= pend_next;
            idx_reg       <= idx_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
        res_reg <= res_next;
    end

endmodule

// ----- src/hvcc_parameter_set_parser.sv -----
// HEVC decoder configuration record parser. Bytes of one record are sent in on
// the s_ channel, one per transfer, with s_record_end set on the final byte, and
// every byte comes back out on the m_ channel exactly once, in order, marked
// with whether it belongs to a VPS, SPS or PPS NAL unit, its kind, and the first
// and last byte of every NAL unit. Checking is done while the record streams
// through, so payload bytes leave before the record is known to be good: the
// first error found is latched and shown on m_status from that byte on, and the
// value of m_status on the byte with m_record_done set is the verdict for the
// whole record. A nonzero verdict means the consumer must discard the record.
// Once an error is latched, the remaining bytes of the record pass through with
// all NAL marks cleared. The block sustains one byte per clock cycle while the
// output is not stalled; the back end updates the parser state for each byte as
// it takes the byte from the queue. A byte passes from the front register into
// the queue and from the queue head into the output register before it is
// offered on the output. A four-entry queue lets the input keep accepting while
// the output is stalled.
module hvcc_parameter_set_parser (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_record_byte,
    input  logic       s_record_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_payload_valid,
    output logic [1:0] m_set_kind,
    output logic       m_nal_first,
    output logic       m_nal_last,
    output logic       m_record_done,
    output logic [2:0] m_status
);
    import hvcc_pkg::*;

    item_t front_item;
    item_t queue_item;
    res_t  back_res;
    logic  front_push;
    logic  queue_ready;
    logic  queue_valid;
    logic  back_pop;

    // The front end registers each byte and works out the byte classes that
    // the parser needs.
    hvcc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_record_byte (s_record_byte),
        .s_record_end  (s_record_end),
        .q_push        (front_push),
        .q_item        (front_item),
        .q_ready       (queue_ready)
    );

    // The queue decouples the input side from stalls on the output side.
    hvcc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (front_push),
        .push_item  (front_item),
        .push_ready (queue_ready),
        .pop        (back_pop),
        .pop_valid  (queue_valid),
        .pop_item   (queue_item)
    );

    // The back end runs the record parser and holds the output register.
    hvcc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (queue_valid),
        .q_item  (queue_item),
        .q_pop   (back_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (back_res)
    );

    assign m_out_byte      = back_res.out_byte;
    assign m_payload_valid = back_res.payload_valid;
    assign m_set_kind      = back_res.set_kind;
    assign m_nal_first     = back_res.nal_first;
    assign m_nal_last      = back_res.nal_last;
    assign m_record_done   = back_res.record_done;
    assign m_status        = back_res.status;

endmodule

// ----- src/hvcc_checker.sv -----
`include "hvcc_parameter_set_parser_defines.svh"

module hvcc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_payload_valid,
    input logic       m_nal_first,
    input logic       m_nal_last,
    input logic       m_record_done,
    input logic [2:0] m_status
);
    import hvcc_pkg::*;

    logic       in_xfer;
    logic       out_xfer;
    logic [3:0] outstanding_reg, outstanding_next;
    logic [2:0] err_seen_reg, err_seen_next;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;

    always_comb begin
        outstanding_next = outstanding_reg;
        if (in_xfer && !out_xfer) begin
            outstanding_next = outstanding_reg + 4'd1;
        end else if (out_xfer && !in_xfer) begin
            outstanding_next = outstanding_reg - 4'd1;
        end
        err_seen_next = err_seen_reg;
        if (out_xfer) begin
            err_seen_next = m_record_done ? ST_OK : m_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= 4'd0;
            err_seen_reg    <= ST_OK;
        end else begin
            outstanding_reg <= outstanding_next;
            err_seen_reg    <= err_seen_next;
        end
    end

    // A stalled result holds.
    `HVCC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_byte) && $stable(m_status) && $stable(m_record_done))

    // No result is offered without an input byte behind it.
    `HVCC_ASSERT_IMP(a_no_invent, aclk, aresetn, m_valid, outstanding_reg != 4'd0)

    // A latched error sticks until the record ends and clears all NAL marks.
    `HVCC_ASSERT_IMP(a_err_sticky, aclk, aresetn, m_valid && err_seen_reg != ST_OK, m_status == err_seen_reg && !m_payload_valid && !m_nal_first && !m_nal_last)

    // The opening byte of a longer NAL in a record that goes on cannot fail.
    `HVCC_ASSERT_IMP(a_first_clean, aclk, aresetn, m_valid && m_nal_first && !m_nal_last && !m_record_done, m_status == ST_OK)

endmodule

bind hvcc_parameter_set_parser hvcc_checker u_hvcc_checker (.*);
